[rtl/core/aes_block_cipher_core_macros.svh]
// assertion helpers for the aes core checker
`ifndef AES_BLOCK_CIPHER_CORE_MACROS_SVH
`define AES_BLOCK_CIPHER_CORE_MACROS_SVH

// property that holds outside reset
`define AES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// property that holds during reset too
`define AES_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");

`endif

[rtl/core/aes_pkg.sv]
`default_nettype none
package aes_pkg;

  localparam int unsigned MaxRoundsDefault = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKey0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeySize = 3'd4;

  localparam logic [1:0] KeySize128 = 2'd0;
  localparam logic [1:0] KeySize192 = 2'd1;

  localparam logic [7:0] GfPoly = 8'h1b;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StInvKey,
    StRound,
    StDone
  } state_e;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  // multiply by a constant of at most four bits
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    sbox_fwd = t[x];
  endfunction

  // inverse sbox as a constant lookup
  function automatic logic [7:0] sbox_inv(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    sbox_inv = t[x];
  endfunction

  function automatic logic [7:0] st_byte(input logic [127:0] s, input int unsigned i);
    st_byte = s[127-8*i -: 8];
  endfunction

  // one round datapath without key addition; the last round skips column mixing
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic inv,
                                            input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] b;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        b = inv ? st_byte(s, 4 * ((c + 4 - r) % 4) + r) : st_byte(s, 4 * ((c + r) % 4) + r);
        t[127-8*(4*c+r) -: 8] = inv ? sbox_inv(b) : sbox_fwd(b);
      end
    end
    for (int c = 0; c < 4; c++) begin
      c0 = st_byte(t, 4*c);
      c1 = st_byte(t, 4*c+1);
      c2 = st_byte(t, 4*c+2);
      c3 = st_byte(t, 4*c+3);
      for (int r = 0; r < 4; r++) begin
        m[127-8*(4*c+r) -: 8] = inv ?
          (gmul(c0, 4'he) ^ gmul(c1, 4'hb) ^ gmul(c2, 4'hd) ^ gmul(c3, 4'h9)) :
          (gmul(c0, 4'h2) ^ gmul(c1, 4'h3) ^ c2 ^ c3);
        {c0, c1, c2, c3} = {c1, c2, c3, c0};
      end
    end
    round_fn = last ? t : m;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    for (int c = 0; c < 4; c++) begin
      c0 = st_byte(s, 4*c);
      c1 = st_byte(s, 4*c+1);
      c2 = st_byte(s, 4*c+2);
      c3 = st_byte(s, 4*c+3);
      for (int r = 0; r < 4; r++) begin
        m[127-8*(4*c+r) -: 8] =
          gmul(c0, 4'he) ^ gmul(c1, 4'hb) ^ gmul(c2, 4'hd) ^ gmul(c3, 4'h9);
        {c0, c1, c2, c3} = {c1, c2, c3, c0};
      end
    end
    inv_mix = m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/aes_block_cipher_core.sv]
// a block transfer runs Nr rounds (Nr = 10/12/14) to the result, done_o after rounds
// after a key write the first block first expands 4*(Nr+1) key words, then inverts the Nr + 1 round keys
// a new block is taken only when idle; the single shared round unit works on one block at a time
// reset clears control state and key registers; round-key stores stay undefined until expanded
// results show for one cycle with done_o; the receiver cannot stall
`default_nettype none
module aes_block_cipher_core #(
  parameter int unsigned MaxRounds = aes_pkg::MaxRoundsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [aes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [aes_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          operation_i,
  input  wire logic [63:0]                   block_high_i,
  input  wire logic [63:0]                   block_low_i,
  output logic                               done_o,
  output logic [63:0]                        result_high_o,
  output logic [63:0]                        result_low_o
);
  import aes_pkg::*;

  localparam int unsigned Depth = MaxRounds + 1;
  localparam int unsigned RkW = $clog2(Depth);
  localparam int unsigned WordCnt = 4 * Depth;
  localparam int unsigned WW = $clog2(WordCnt + 1);

  logic [63:0] key_q [4];
  logic [1:0] ksize_q;
  logic expanded_q, expanded_d;
  state_e state_q, state_d;
  logic [127:0] st_q, st_d;
  logic dec_q, dec_d;
  logic [RkW-1:0] rnd_q, rnd_d;
  logic [WW-1:0] wi_q, wi_d;
  logic [31:0] win_q [8];
  logic [7:0] rcon_q, rcon_d;
  logic [3:0] nk;
  logic [RkW-1:0] nr;
  logic [2:0] pos_q, pos_d;

  logic [127:0] enc_mem [Depth];
  logic [127:0] dec_mem [Depth];
  logic [127:0] ek_rd_q, dk_rd_q;
  logic [RkW-1:0] rd_addr;
  logic [127:0] wbuf_q;
  logic [31:0] new_w;
  logic [31:0] t_w;
  logic w_commit;
  logic [RkW-1:0] inv_wr_addr;
  logic inv_wr;

  // effective key size after clamping to the round budget
  always_comb begin
    nk = (ksize_q == KeySize128) ? 4'd4 : ((ksize_q == KeySize192) ? 4'd6 : 4'd8);
    if (nk > 4'd4 && 32'(nk) + 6 > MaxRounds) nk = nk - 4'd2;
    if (nk > 4'd4 && 32'(nk) + 6 > MaxRounds) nk = nk - 4'd2;
    nr = RkW'(nk + 4'd6);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      ksize_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey0: key_q[0] <= cfg_data_i;
        RegKey1: key_q[1] <= cfg_data_i;
        RegKey2: key_q[2] <= cfg_data_i;
        RegKey3: key_q[3] <= cfg_data_i;
        RegKeySize: ksize_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // next key word from the sliding window of the last nk words
  always_comb begin
    t_w = win_q[3'(nk - 4'd1)];
    if (pos_q == 3'd0) begin
      t_w = {sbox_fwd(t_w[23:16]) ^ rcon_q, sbox_fwd(t_w[15:8]), sbox_fwd(t_w[7:0]),
             sbox_fwd(t_w[31:24])};
    end else if (nk == 4'd8 && pos_q == 3'd4) begin
      t_w = {sbox_fwd(t_w[31:24]), sbox_fwd(t_w[23:16]), sbox_fwd(t_w[15:8]),
             sbox_fwd(t_w[7:0])};
    end
    new_w = (wi_q < WW'(nk)) ? (wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32])
                              : (win_q[0] ^ t_w);
  end

  assign w_commit = (state_q == StExpand) && (wi_q[1:0] == 2'd3);

  // round key stores
  always_ff @(posedge clk_i) begin
    if (w_commit) enc_mem[wi_q[WW-1:2]] <= {wbuf_q[95:0], new_w};
    if (inv_wr) dec_mem[inv_wr_addr] <= (inv_wr_addr == '0 || inv_wr_addr == nr) ?
                                         ek_rd_q : inv_mix(ek_rd_q);
    ek_rd_q <= enc_mem[rd_addr];
    dk_rd_q <= dec_mem[rd_addr];
  end

  // expansion window and word buffer, newest word at slot nk-1
  always_ff @(posedge clk_i) begin
    if (state_q == StExpand) begin
      for (int i = 0; i < 7; i++) win_q[i] <= (i == int'(nk) - 1) ? new_w : win_q[i+1];
      win_q[7] <= new_w;
      wbuf_q <= {wbuf_q[95:0], new_w};
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      expanded_q <= 1'b0;
      rnd_q <= '0;
      wi_q <= '0;
      rcon_q <= 8'h01;
      pos_q <= '0;
    end else begin
      state_q <= state_d;
      expanded_q <= expanded_d;
      rnd_q <= rnd_d;
      wi_q <= wi_d;
      rcon_q <= rcon_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    dec_q <= dec_d;
  end

  // sequencer: key expansion, key inversion and rounds
  always_comb begin
    state_d = state_q;
    expanded_d = expanded_q;
    rnd_d = rnd_q;
    wi_d = wi_q;
    rcon_d = rcon_q;
    pos_d = pos_q;
    st_d = st_q;
    dec_d = dec_q;
    rd_addr = rnd_q;
    inv_wr = 1'b0;
    inv_wr_addr = '0;
    done_o = 1'b0;
    if (cfg_we_i && 32'(cfg_idx_i) <= 32'(RegKeySize)) expanded_d = 1'b0;
    case (state_q)
      StIdle: begin
        rd_addr = '0;
        if (start_i) begin
          st_d = {block_high_i, block_low_i};
          dec_d = operation_i;
          rnd_d = '0;
          if (!expanded_q) begin
            state_d = StExpand;
            wi_d = '0;
            pos_d = '0;
            rcon_d = 8'h01;
          end else begin
            state_d = StRound;
          end
        end
      end
      StExpand: begin
        wi_d = wi_q + 1'b1;
        if (wi_q >= WW'(nk)) begin
          if (pos_q == 3'd0) rcon_d = xtime(rcon_q);
        end
        pos_d = (pos_q == 3'(nk - 4'd1)) ? 3'd0 : pos_q + 3'd1;
        if (wi_q == WW'(4 * (32'(nr) + 1) - 1)) begin
          state_d = StInvKey;
          rnd_d = '0;
        end
        if (wi_q < WW'(nk) && wi_q == WW'(nk - 4'd1)) pos_d = 3'd0;
      end
      StInvKey: begin
        // read enc key nr-rnd, write it as dec key rnd in the next cycle
        rd_addr = nr - rnd_q;
        inv_wr = (rnd_q != '0);
        inv_wr_addr = rnd_q - 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == nr + 1'b1) begin
          state_d = StRound;
          expanded_d = 1'b1;
          rnd_d = '0;
        end
      end
      StRound: begin
        // rnd_q = 0 fetches key 0, rnd_q = 1 adds it; later steps apply rounds
        rd_addr = rnd_q + 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == '0) begin
          st_d = st_q;
          rd_addr = '0;
        end
        if (rnd_q == 1) st_d = st_q ^ (dec_q ? dk_rd_q : ek_rd_q);
        else if (rnd_q != '0) begin
          st_d = round_fn(st_q, dec_q, rnd_q == nr + 1'b1) ^ (dec_q ? dk_rd_q : ek_rd_q);
        end
        if (rnd_q == 1) rd_addr = 1;
        else if (rnd_q != '0) rd_addr = rnd_q;
        if (rnd_q == nr + 1'b1) state_d = StDone;
      end
      StDone: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign result_high_o = st_q[127:64];
  assign result_low_o = st_q[63:0];

endmodule
`default_nettype wire

[rtl/core/aes_chk.sv]
`default_nettype none
`include "aes_block_cipher_core_macros.svh"
module aes_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o
);
  // a transfer starts the core
  `AES_ASSERT(start_sets_busy, (start_i && !busy_o) |=> busy_o)
  // a result leaves the core idle next cycle
  `AES_ASSERT(done_then_idle, done_o |=> !busy_o)
  // result only comes out while busy
  `AES_ASSERT(done_while_busy, done_o |-> busy_o)
  // no result right after an accepted block
  `AES_ASSERT(no_early_done, (start_i && !busy_o) |=> !done_o)
  // no result during reset
  `AES_ASSERT_ALWAYS(reset_idle, !rst_ni |-> !done_o)
endmodule

bind aes_block_cipher_core aes_chk u_aes_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .done_o(done_o)
);
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
  import aes_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                start_i = 1'b0;
  logic                operation_i = 1'b0;
  logic [63:0]         block_high_i = '0;
  logic [63:0]         block_low_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [63:0]         result_high_o;
  logic [63:0]         result_low_o;

  aes_block_cipher_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start_i(start_i), .busy_o(busy_o),
    .operation_i(operation_i), .block_high_i(block_high_i), .block_low_i(block_low_i),
    .done_o(done_o), .result_high_o(result_high_o), .result_low_o(result_low_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
  } cipher_out_t;

  cipher_out_t expected_blocks[$];
  int unsigned fail_count = 0;
  int unsigned blocks_sent = 0;
  bit          no_idle = 1'b0;

  // predictor state
  logic [7:0]   fwd_tab [256];
  logic [7:0]   inv_tab [256];
  logic [63:0]  key_word [4];
  logic [1:0]   key_len_code;
  bit           schedule_ready;
  int unsigned  rounds;
  logic [127:0] enc_keys [15];
  logic [127:0] dec_keys [15];

  function automatic logic [7:0] times_x(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = times_x(a);
    end
    return acc;
  endfunction

  // substitution tables from field inverse plus affine map
  task automatic build_tables();
    logic [7:0] inv;
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = field_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_tab[x] = v;
      inv_tab[v] = x[7:0];
    end
  endtask

  function automatic logic [127:0] sub_and_shift(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int src;
    logic [7:0] v;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        v = s[127-8*(4*src+r) -: 8];
        t[127-8*(4*c+r) -: 8] = inv ? inv_tab[v] : fwd_tab[v];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
    logic [127:0] m;
    logic [7:0] col [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++) begin
        if (inv)
          m[127-8*(4*c+r) -: 8] = field_mul(8'h0e, col[r]) ^ field_mul(8'h0b, col[(r+1)%4])
                                  ^ field_mul(8'h0d, col[(r+2)%4])
                                  ^ field_mul(8'h09, col[(r+3)%4]);
        else
          m[127-8*(4*c+r) -: 8] = field_mul(8'h02, col[r]) ^ field_mul(8'h03, col[(r+1)%4])
                                  ^ col[(r+2)%4] ^ col[(r+3)%4];
      end
    end
    return m;
  endfunction

  // key schedule into both round key stores
  task automatic expand_schedule();
    logic [31:0] w [68];
    logic [31:0] t;
    logic [7:0] rc;
    int nk;
    int kb;
    nk = (key_len_code >= 2) ? 8 : (key_len_code == 1 ? 6 : 4);
    rounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      for (int j = 0; j < 4; j++) begin
        kb = 4 * i + j;
        w[i][31-8*j -: 8] = 8'(key_word[kb/8] >> (8 * (7 - kb % 8)));
      end
    for (int i = nk; i < 4 * (rounds + 1); i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = {fwd_tab[t[23:16]] ^ rc, fwd_tab[t[15:8]], fwd_tab[t[7:0]], fwd_tab[t[31:24]]};
        rc = times_x(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= rounds; r++) enc_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    dec_keys[0] = enc_keys[rounds];
    for (int r = 1; r < rounds; r++) dec_keys[r] = mix_columns(enc_keys[rounds-r], 1'b1);
    dec_keys[rounds] = enc_keys[0];
    schedule_ready = 1'b1;
  endtask

  task automatic predict_cipher(input bit decrypt, input logic [63:0] hi,
                                input logic [63:0] lo);
    logic [127:0] s;
    cipher_out_t e;
    if (!schedule_ready) expand_schedule();
    s = {hi, lo} ^ (decrypt ? dec_keys[0] : enc_keys[0]);
    for (int r = 1; r < rounds; r++)
      s = mix_columns(sub_and_shift(s, decrypt), decrypt) ^ (decrypt ? dec_keys[r] : enc_keys[r]);
    s = sub_and_shift(s, decrypt) ^ (decrypt ? dec_keys[rounds] : enc_keys[rounds]);
    e.high = s[127:64];
    e.low = s[63:0];
    expected_blocks.push_back(e);
  endtask

  // result checker
  always @(posedge clk_i) begin
    cipher_out_t e;
    if (rst_ni && done_o) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result transfer %h %h", result_high_o, result_low_o);
        fail_count++;
      end else begin
        e = expected_blocks.pop_front();
        if (result_high_o !== e.high) begin
          $error("result_high expected %h actual %h", e.high, result_high_o);
          fail_count++;
        end
        if (result_low_o !== e.low) begin
          $error("result_low expected %h actual %h", e.low, result_low_o);
          fail_count++;
        end
      end
    end
  end

  // wait until all results are back and the core is idle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_blocks.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= RegKey3) begin
      key_word[idx[1:0]] = data;
      schedule_ready = 1'b0;
    end else if (idx == RegKeySize) begin
      key_len_code = data[1:0];
      schedule_ready = 1'b0;
    end
    @(posedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3,
                          input logic [63:0] size_word);
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
    write_reg(RegKeySize, size_word);
  endtask

  // one block transfer, start stays high afterwards
  task automatic send_block(input bit decrypt, input logic [63:0] hi, input logic [63:0] lo);
    start_i <= 1'b1;
    operation_i <= decrypt;
    block_high_i <= hi;
    block_low_i <= lo;
    do @(posedge clk_i); while (busy_o);
    predict_cipher(decrypt, hi, lo);
    blocks_sent++;
  endtask

  task automatic maybe_idle();
    if (!no_idle && $urandom_range(99) < 28) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // known answer vectors and field extremes for each key size
  task automatic test_directed();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f, {62'h0, KeySize128});
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    drain();
    write_reg(RegKeySize, {62'h0, KeySize192});
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h0, 64'h0);
    drain();
    write_reg(RegKeySize, 64'h2);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, '1, '1);
    drain();
    // unused size code behaves as the longest key, upper data bits ignored
    load_key('1, '1, '1, '1, '1);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, 64'h0);
    drain();
    load_key('0, '0, '0, '0, {62'h0, KeySize128});
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '1);
    drain();
    // out of range register indexes leave the schedule alone
    for (int i = RegKeySize + 1; i < 8; i++) write_reg(i[CfgIdxW-1:0], rand64());
    send_block(1'b0, 64'h8000000000000000, 64'h1);
    send_block(1'b1, 64'h1, 64'h8000000000000000);
    drain();
  endtask

  // random key phases with random block traffic
  task automatic test_random_traffic();
    int phase;
    int count;
    logic [63:0] k [4];
    phase = 0;
    while (blocks_sent < 1400) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(9))
          0: k[i] = '0;
          1: k[i] = '1;
          default: k[i] = rand64();
        endcase
      end
      load_key(k[0], k[1], k[2], k[3], (rand64() & ~64'h3) | 64'(phase % 4));
      no_idle = (phase == 5);
      count = $urandom_range(30, 70);
      for (int n = 0; n < count; n++) begin
        maybe_idle();
        if (phase == 3 && n == count / 2) drain();
        send_block($urandom_range(1), rand64(), rand64());
      end
      drain();
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // key size change only, keeping key bytes
  task automatic test_size_rewrite();
    for (int sz = 0; sz < 4; sz++) begin
      write_reg(RegKeySize, 64'(sz));
      for (int n = 0; n < 6; n++) begin
        maybe_idle();
        send_block($urandom_range(1), rand64(), rand64());
      end
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_word[i] = '0;
    key_len_code = KeySize128;
    schedule_ready = 1'b0;
    // falling edge so the asynchronous reset takes effect
    #1 rst_ni <= 1'b0;
    build_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_size_rewrite();
    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("PASS aes_block_cipher_core");
    end else begin
      $display("FAIL aes_block_cipher_core");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(4 * 1000000);
    $display("FAIL aes_block_cipher_core");
    $finish;
  end

endmodule
`default_nettype wire
